FILE: design/ple_pkg.sv
// Package for the positional list engine: types, sizes and codes.
`default_nettype none
package ple_pkg;
    localparam int Capacity = 32;
    localparam int IdxW     = $clog2(Capacity);
    localparam int LenW     = $clog2(Capacity + 1);

    localparam logic [2:0] FN_INSERT = 3'd0;
    localparam logic [2:0] FN_REMOVE = 3'd1;
    localparam logic [2:0] FN_READ   = 3'd2;
    localparam logic [2:0] FN_MOVE   = 3'd3;
    localparam logic [2:0] FN_REV    = 3'd4;
    localparam logic [2:0] FN_ROTL   = 3'd5;
    localparam logic [2:0] FN_ROTR   = 3'd6;
    localparam logic [2:0] FN_NOP    = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] item_value;
        logic [5:0]         pos_a;
        logic [4:0]         pos_b;
        logic [5:0]         amount;
    } t_req;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               last;
        logic               list_empty;
        logic [1:0]         status;
    } t_res;
endpackage
`default_nettype wire

FILE: design/positional_list_engine.sv
// Top level of the positional list engine: command sequencer around the element store.
// Insert shifts elements up, remove shifts them down and reverse swaps pairs; move first
// closes the gap, then reopens it; rotate first reduces the amount modulo the length by
// repeated subtraction, then copies the rotated list into scratch and back; readout emits
// the elements one at a time. One request at a time: busy stays high until the last result.
// Results strobed for one cycle, receiver cannot stall; sync active-low reset empties list.
`default_nettype none
module positional_list_engine
    import ple_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_valid,
    output t_res      o_res
);
    // States
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1; // issue read for the current step
    localparam logic [2:0] S_WR   = 3'd2; // data back, write the destination slot
    localparam logic [2:0] S_MOD  = 3'd3; // amount mod length by subtraction
    localparam logic [2:0] S_DONE = 3'd4; // status result

    // Pass kinds: each pass is a series of read-then-write steps
    localparam logic [2:0] P_SHR  = 3'd0; // shift up (open gap), walking down
    localparam logic [2:0] P_SHL  = 3'd1; // shift down (close gap), walking up
    localparam logic [2:0] P_RD   = 3'd2; // readout
    localparam logic [2:0] P_REV  = 3'd3; // swap pairs
    localparam logic [2:0] P_ROT  = 3'd4; // copy rotated into scratch
    localparam logic [2:0] P_BACK = 3'd5; // copy scratch back
    localparam logic [2:0] P_MOVR = 3'd6; // move: fetch element to hold

    logic [2:0]       r_state;
    logic [2:0]       r_pass;
    t_req             r_req;
    logic [LenW-1:0]  r_len;
    logic [LenW-1:0]  r_k;      // step counter
    logic [LenW-1:0]  r_end;
    logic [LenW-1:0]  r_amt;    // rotation / reduction
    logic [1:0]       r_stat;
    logic             r_phase;  // reverse: second half of a swap
    logic             r_mvph;   // move: 0 close gap, 1 open gap
    logic [31:0]      r_hold, r_tmp;

    // Store and scratch
    logic             mem_we, scr_we;
    logic [IdxW-1:0]  mem_wa, mem_ra, scr_ra;
    logic [31:0]      mem_wd, mem_rd, scr_rd;

    ple_mem u_mem (.i_clk, .i_we(mem_we), .i_waddr(mem_wa), .i_wdata(mem_wd),
                   .i_raddr(mem_ra), .o_rdata(mem_rd));
    ple_mem u_scr (.i_clk, .i_we(scr_we), .i_waddr(r_k[IdxW-1:0]), .i_wdata(mem_rd),
                   .i_raddr(scr_ra), .o_rdata(scr_rd));

    // rotated source index: (k + amt) wrapped once, since both are below len
    logic [LenW:0] rot_sum;
    logic [LenW:0] rot_idx;
    assign rot_sum = {1'b0, r_k} + {1'b0, r_amt};
    assign rot_idx = (rot_sum >= {1'b0, r_len}) ? rot_sum - {1'b0, r_len} : rot_sum;

    // read address per pass
    logic [LenW-1:0] rev_hi;
    assign rev_hi = r_len - 1'b1 - r_k;
    always_comb begin
        case (r_pass)
            P_SHR:   mem_ra = IdxW'(r_k - 1'b1);
            P_SHL:   mem_ra = IdxW'(r_k + 1'b1);
            P_REV:   mem_ra = r_phase ? IdxW'(rev_hi) : IdxW'(r_k);
            P_ROT:   mem_ra = IdxW'(rot_idx);
            P_MOVR:  mem_ra = IdxW'(r_req.pos_a);
            default: mem_ra = IdxW'(r_k);
        endcase
    end
    assign scr_ra = r_k[IdxW-1:0];

    assign busy = (r_state != S_IDLE);

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_k[IdxW-1:0];
        mem_wd = mem_rd;
        scr_we = 1'b0;
        if (r_state == S_WR) begin
            case (r_pass)
                P_SHR, P_SHL: mem_we = 1'b1;
                P_REV: begin
                    mem_we = r_phase;
                    mem_wa = r_phase ? IdxW'(r_k) : IdxW'(rev_hi);
                end
                P_ROT:  scr_we = 1'b1;
                P_BACK: begin
                    mem_we = 1'b1;
                    mem_wd = scr_rd;
                end
                default: mem_we = 1'b0;
            endcase
        end else if (r_state == S_RD && r_pass == P_REV && r_phase) begin
            // saved low word goes high; the read of the high slot still sees the old word
            mem_we = 1'b1;
            mem_wa = IdxW'(rev_hi);
            mem_wd = r_tmp;
        end else if (r_state == S_DONE && r_stat == ST_OK) begin
            // final insertion write for insert and move
            if (r_req.func == FN_INSERT) begin
                mem_we = 1'b1;
                mem_wa = IdxW'(r_req.pos_a);
                mem_wd = r_req.item_value;
            end else if (r_req.func == FN_MOVE) begin
                mem_we = 1'b1;
                mem_wa = IdxW'(r_req.pos_b);
                mem_wd = r_hold;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req   <= i_req;
                        r_stat  <= ST_OK;
                        r_phase <= 1'b0;
                        r_mvph  <= 1'b0;
                        r_amt   <= LenW'(i_req.amount);
                        r_state <= S_DONE;
                        case (i_req.func)
                            FN_INSERT: begin
                                if (LenW'(i_req.pos_a) > r_len) r_stat <= ST_RANGE;
                                else if (r_len >= LenW'(Capacity)) r_stat <= ST_FULL;
                                else if (r_len != LenW'(i_req.pos_a)) begin
                                    r_pass <= P_SHR; r_k <= r_len;
                                    r_end <= LenW'(i_req.pos_a); r_state <= S_RD;
                                end
                            end
                            FN_REMOVE: begin
                                if (LenW'(i_req.pos_a) >= r_len) r_stat <= ST_RANGE;
                                else begin
                                    r_pass <= P_SHL; r_k <= LenW'(i_req.pos_a);
                                    r_end <= r_len - 1'b1; r_state <= S_RD;
                                end
                            end
                            FN_READ: begin
                                r_pass <= P_RD; r_k <= '0;
                                r_end <= r_len; r_state <= S_RD;
                            end
                            FN_MOVE: begin
                                if (LenW'(i_req.pos_a) >= r_len ||
                                    LenW'(i_req.pos_b) >= r_len) r_stat <= ST_RANGE;
                                else begin
                                    r_pass <= P_MOVR; r_state <= S_RD;
                                end
                            end
                            FN_REV: begin
                                r_pass <= P_REV; r_k <= '0;
                                r_end <= r_len >> 1; r_state <= S_RD;
                            end
                            FN_ROTL, FN_ROTR: begin
                                if (r_len == '0) r_stat <= ST_RANGE;
                                else r_state <= S_MOD;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_MOD: begin
                    // amount mod length, one subtraction a cycle
                    if (r_amt >= r_len) r_amt <= r_amt - r_len;
                    else begin
                        if (r_req.func == FN_ROTR && r_amt != '0)
                            r_amt <= r_len - r_amt;
                        r_pass <= P_ROT; r_k <= '0;
                        r_end <= r_len; r_state <= S_RD;
                    end
                end
                S_RD: begin
                    // loop finished?
                    if ((r_pass == P_SHR && r_k == r_end) ||
                        (r_pass != P_SHR && r_pass != P_MOVR && r_k >= r_end)) begin
                        if (r_pass == P_ROT) begin
                            r_pass <= P_BACK; r_k <= '0;
                        end else if (r_pass == P_SHL && r_req.func == FN_MOVE
                                     && !r_mvph) begin
                            // close done, length now len-1: open gap at pos_b
                            r_mvph <= 1'b1; r_pass <= P_SHR;
                            r_k <= r_len - 1'b1; r_end <= LenW'(r_req.pos_b);
                        end else if (r_pass == P_RD) begin
                            if (r_len == '0) begin
                                o_valid <= 1'b1;
                                o_res   <= '{read_value: '0, last: 1'b1,
                                             list_empty: 1'b1, status: ST_OK};
                            end
                            r_state <= S_IDLE;
                        end else r_state <= S_DONE;
                    end else r_state <= S_WR;
                end
                S_WR: begin
                    r_state <= S_RD;
                    case (r_pass)
                        P_SHR: r_k <= r_k - 1'b1;
                        P_RD: begin
                            o_valid <= 1'b1;
                            o_res   <= '{read_value: mem_rd,
                                         last: (r_k + 1'b1 == r_len),
                                         list_empty: 1'b0, status: ST_OK};
                            r_k <= r_k + 1'b1;
                        end
                        P_REV: begin
                            // phase 0 saves the low word; phase 1 writes the high word low
                            r_phase <= ~r_phase;
                            if (!r_phase) r_tmp <= mem_rd;
                            else r_k <= r_k + 1'b1;
                        end
                        P_MOVR: begin
                            r_hold <= mem_rd;
                            r_pass <= P_SHL; r_k <= LenW'(r_req.pos_a);
                            r_end  <= r_len - 1'b1;
                        end
                        default: r_k <= r_k + 1'b1;
                    endcase
                end
                S_DONE: begin
                    o_valid <= 1'b1;
                    o_res   <= '{read_value: '0, last: 1'b1,
                                 list_empty: 1'b0, status: r_stat};
                    if (r_stat == ST_OK) begin
                        if (r_req.func == FN_INSERT) r_len <= r_len + 1'b1;
                        else if (r_req.func == FN_REMOVE) r_len <= r_len - 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: design/ple_mem.sv
// Element store: 32-word memory, one write port and one registered read port.
`default_nettype none
module ple_mem
    import ple_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [IdxW-1:0]   i_waddr,
    input  wire logic [31:0]       i_wdata,
    input  wire logic [IdxW-1:0]   i_raddr,
    output logic      [31:0]       o_rdata
);
    logic [31:0] r_mem [Capacity];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
